// File: rtl/pic_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the point-in-convex-polygon block
// no dependencies

package pic_pkg;

    // fixed field widths
    localparam int COORD_W  = 24;  // signed Q13.10 coordinate
    localparam int DIFF_W   = 25;  // exact coordinate difference, Q14.10
    localparam int PROD_W   = 50;  // exact product, Q29.20
    localparam int CROSS_W  = 51;  // exact cross product, Q30.20
    localparam int SLOT_W   = 4;   // vertex_index field
    localparam int CFG_W    = 5;   // vertex_count register
    localparam int S_DATA_W = 56;  // slave tdata, padded to whole bytes
    localparam int M_DATA_W = 8;   // master tdata, padded to whole bytes

    // fewest vertices that make a polygon
    localparam int MIN_VERTICES = 3;

    // operation codes carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;

    // query sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL1,
        ST_MUL2,
        ST_SIGN,
        ST_DONE
    } t_state;

    // vertex pair read back from the store for one edge
    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_edge;

endpackage

// File: rtl/point_in_convex_polygon_top.sv
`timescale 1ns / 1ps
// point-in-convex-polygon test: stream handshake, query sequencer, sign tracking
// depends on pic_pkg, pic_vstore, pic_mul
//
// Usage
//   Slave channel takes one word per item. tuser selects the operation: a write
//   stores (x, y) at vertex_index, a query tests point (x, y) against the polygon
//   made of slots 0 .. vertex_count-1 (clamped to MAX_VERTICES).
//   A write gives no result and the block is ready again in the next cycle.
//   A query gives one master word: bit 0 is 1 when the point is inside or on
//   the boundary. Each edge passes through the shared multiplier (difference,
//   two products, sign check). A query ends early when an opposite sign is
//   found; with fewer than three vertices it goes straight to its final state
//   and answers outside. tready stays low while a query runs, so the next
//   query is taken only after the last one is done.
//   vertex_count is written through i_cfg_we / i_cfg_wdata; the user writes it
//   only while the block idles, as the block itself does not enforce this.
//   Reset clears the sequencer, the output valid and vertex_count; the vertex
//   store is not cleared and must be written before it is queried.
//   A stalled master side holds the result word; the block keeps taking words,
//   but the next query waits in its final state, accepting nothing, until that
//   word is taken.

module point_in_convex_polygon_top #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pic_pkg::S_DATA_W-1:0]   i_s_tdata,  // vertex_index[3:0], x[27:4], y[51:28], zero
    input  logic                           i_s_tuser,  // operation
    // master stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [pic_pkg::M_DATA_W-1:0]   o_m_tdata,  // inside_res[0], zero
    // configuration
    input  logic                           i_cfg_we,
    input  logic [pic_pkg::CFG_W-1:0]      i_cfg_wdata // vertex_count
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = IDX_W + 1;
    localparam int CW    = (CNT_W > pic_pkg::CFG_W) ? CNT_W : pic_pkg::CFG_W;
    localparam int SW    = (CNT_W > pic_pkg::SLOT_W) ? CNT_W : pic_pkg::SLOT_W;

    // input word fields
    logic [pic_pkg::SLOT_W-1:0] w_slot;
    pic_pkg::t_coord            w_x;
    pic_pkg::t_coord            w_y;
    logic                       w_accept;

    assign w_slot   = i_s_tdata[pic_pkg::SLOT_W-1:0];
    assign w_x      = i_s_tdata[pic_pkg::SLOT_W +: pic_pkg::COORD_W];
    assign w_y      = i_s_tdata[pic_pkg::SLOT_W + pic_pkg::COORD_W +: pic_pkg::COORD_W];
    assign w_accept = i_s_tvalid && o_s_tready;

    // registers
    pic_pkg::t_state          r_state, n_state;
    logic [pic_pkg::CFG_W-1:0] r_vcount;
    logic [CNT_W-1:0]         r_n, n_n;
    logic [IDX_W-1:0]         r_idx, n_idx;
    pic_pkg::t_coord          r_px, r_py;
    pic_pkg::t_diff           r_ex, r_ey, r_dx, r_dy;
    pic_pkg::t_prod           r_p1;
    logic                     r_have_sign;
    logic                     r_neg;
    logic                     r_res;
    logic                     r_out_valid;

    // datapath controls from the output decode
    logic                     w_start;
    logic                     w_load_diff;
    logic                     w_load_p1;
    logic                     w_check;
    logic                     w_load_out;
    pic_pkg::t_diff           w_mul_a, w_mul_b;

    // clamp of vertex_count to the store depth
    logic [CW-1:0]            w_cfg_ext;
    logic [CW-1:0]            w_clamp;

    assign w_cfg_ext = CW'(r_vcount);
    assign w_clamp   = (w_cfg_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : w_cfg_ext;

    // edge walk indexes
    logic [CNT_W-1:0]         w_idx_p1;
    logic [CNT_W-1:0]         w_nidx_p1;
    logic [IDX_W-1:0]         w_rd_b;
    logic                     w_last;
    logic                     w_few;

    assign w_idx_p1  = {1'b0, r_idx} + CNT_W'(1);
    assign w_last    = (w_idx_p1 == r_n);
    assign w_nidx_p1 = {1'b0, n_idx} + CNT_W'(1);
    assign w_rd_b    = (w_nidx_p1 == n_n) ? '0 : w_nidx_p1[IDX_W-1:0];
    assign w_few     = (CW'(w_clamp) < CW'(pic_pkg::MIN_VERTICES));

    // vertex store write
    logic                     w_we;
    pic_pkg::t_edge           w_edge;

    assign w_we = w_accept && (i_s_tuser == pic_pkg::OP_WRITE)
                  && (SW'(w_slot) < SW'(MAX_VERTICES));

    pic_vstore #(
        .DEPTH (MAX_VERTICES)
    ) u_vstore (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (IDX_W'(w_slot)),
        .i_wx      (w_x),
        .i_wy      (w_y),
        .i_raddr_a (n_idx),
        .i_raddr_b (w_rd_b),
        .o_edge    (w_edge)
    );

    // shared multiplier
    pic_pkg::t_prod           w_prod;

    pic_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // cross product sign of the current edge
    pic_pkg::t_cross          w_cross;
    logic                     w_nz;
    logic                     w_cneg;
    logic                     w_mismatch;

    assign w_cross    = pic_pkg::t_cross'(r_p1) - pic_pkg::t_cross'(w_prod);
    assign w_nz       = (w_cross != '0);
    assign w_cneg     = w_cross[pic_pkg::CROSS_W-1];
    assign w_mismatch = w_nz && r_have_sign && (w_cneg != r_neg);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pic_pkg::ST_IDLE: begin
                if (w_accept && (i_s_tuser == pic_pkg::OP_QUERY)) begin
                    n_state = w_few ? pic_pkg::ST_DONE : pic_pkg::ST_DIFF;
                end
            end
            pic_pkg::ST_DIFF: n_state = pic_pkg::ST_MUL1;
            pic_pkg::ST_MUL1: n_state = pic_pkg::ST_MUL2;
            pic_pkg::ST_MUL2: n_state = pic_pkg::ST_SIGN;
            pic_pkg::ST_SIGN: begin
                n_state = (w_mismatch || w_last) ? pic_pkg::ST_DONE : pic_pkg::ST_DIFF;
            end
            pic_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = pic_pkg::ST_IDLE;
                end
            end
            default: n_state = pic_pkg::ST_IDLE;
        endcase
    end

    // output decode
    always_comb begin
        w_start     = 1'b0;
        w_load_diff = 1'b0;
        w_load_p1   = 1'b0;
        w_check     = 1'b0;
        w_load_out  = 1'b0;
        w_mul_a     = r_ey;
        w_mul_b     = r_dx;
        n_idx       = r_idx;
        n_n         = r_n;
        unique case (r_state)
            pic_pkg::ST_IDLE: begin
                if (w_accept && (i_s_tuser == pic_pkg::OP_QUERY)) begin
                    w_start = 1'b1;
                    n_idx   = '0;
                    n_n     = CNT_W'(w_clamp);
                end
            end
            pic_pkg::ST_DIFF: w_load_diff = 1'b1;
            pic_pkg::ST_MUL1: begin
                w_mul_a = r_ex;
                w_mul_b = r_dy;
            end
            pic_pkg::ST_MUL2: w_load_p1 = 1'b1;
            pic_pkg::ST_SIGN: begin
                w_check = 1'b1;
                if (!w_mismatch && !w_last) begin
                    n_idx = w_idx_p1[IDX_W-1:0];
                end
            end
            pic_pkg::ST_DONE: w_load_out = !r_out_valid || i_m_tready;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pic_pkg::ST_IDLE;
            r_vcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query datapath registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_n   <= n_n;
        if (w_start) begin
            r_px        <= w_x;
            r_py        <= w_y;
            r_have_sign <= 1'b0;
            r_neg       <= 1'b0;
            r_res       <= !w_few;
        end
        if (w_load_diff) begin
            r_ex <= pic_pkg::t_diff'(w_edge.bx) - pic_pkg::t_diff'(w_edge.ax);
            r_ey <= pic_pkg::t_diff'(w_edge.by) - pic_pkg::t_diff'(w_edge.ay);
            r_dx <= pic_pkg::t_diff'(r_px) - pic_pkg::t_diff'(w_edge.ax);
            r_dy <= pic_pkg::t_diff'(r_py) - pic_pkg::t_diff'(w_edge.ay);
        end
        if (w_load_p1) begin
            r_p1 <= w_prod;
        end
        if (w_check) begin
            if (w_nz && !r_have_sign) begin
                r_have_sign <= 1'b1;
                r_neg       <= w_cneg;
            end
            if (w_mismatch) begin
                r_res <= 1'b0;
            end
        end
    end

    // output word register
    logic r_out_bit;

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_bit <= r_res;
        end
    end

    assign o_s_tready = (r_state == pic_pkg::ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(pic_pkg::M_DATA_W-1){1'b0}}, r_out_bit};

    // a result word appears only as a query finishes
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == pic_pkg::ST_DONE))
        else $error("result word without a finished query");

    // fewer than three vertices always answer outside
    a_few_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pic_pkg::ST_DONE && r_n < CNT_W'(pic_pkg::MIN_VERTICES)) |-> !r_res)
        else $error("degenerate polygon reported inside");

    // the edge walk never passes the vertex count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pic_pkg::ST_DIFF || r_state == pic_pkg::ST_SIGN)
        |-> ({1'b0, r_idx} < r_n))
        else $error("edge index beyond vertex count");

    // a finished query waits while the result word is stalled
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pic_pkg::ST_DONE && o_m_tvalid && !i_m_tready)
        |=> (r_state == pic_pkg::ST_DONE))
        else $error("query result lost under stall");

endmodule

// File: rtl/pic_vstore.sv
`timescale 1ns / 1ps
// vertex store: one write port, two registered read ports (edge start and end)
// depends on pic_pkg

module pic_vstore #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  pic_pkg::t_coord          i_wx,
    input  pic_pkg::t_coord          i_wy,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output pic_pkg::t_edge           o_edge
);

    localparam int ENTRY_W = 2 * pic_pkg::COORD_W;

    // x in the upper half, y in the lower half
    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_a;
    logic [ENTRY_W-1:0] r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wx, i_wy};
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_edge.ax = r_rd_a[ENTRY_W-1:pic_pkg::COORD_W];
    assign o_edge.ay = r_rd_a[pic_pkg::COORD_W-1:0];
    assign o_edge.bx = r_rd_b[ENTRY_W-1:pic_pkg::COORD_W];
    assign o_edge.by = r_rd_b[pic_pkg::COORD_W-1:0];

endmodule

// File: rtl/pic_mul.sv
`timescale 1ns / 1ps
// shared signed multiplier with registered product, used twice per edge
// depends on pic_pkg

module pic_mul (
    input  logic           i_clk,
    input  pic_pkg::t_diff i_a,
    input  pic_pkg::t_diff i_b,
    output pic_pkg::t_prod o_prod
);

    pic_pkg::t_prod r_prod;

    // full-precision registered product; operands sign-extended to the product width
    always_ff @(posedge i_clk) begin
        r_prod <= pic_pkg::t_prod'(i_a) * pic_pkg::t_prod'(i_b);
    end

    assign o_prod = r_prod;

endmodule
